// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_CHECK(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion check failed");

`define ASSERT_NEVER(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("assertion never failed");

`else

`define ASSERT_CHECK(name, clk, rstn, prop)

`define ASSERT_NEVER(name, clk, rstn, prop)

`endif

`endif

// ----- rtl/core/dam_pkg.sv -----
// ----------------------------------------------------------------------------
// dam_pkg
// Shared types and constants of the deviation alarm monitor.
// ----------------------------------------------------------------------------
package dam_pkg;

  localparam int AddrWidth = 5;
  localparam int DataWidth = 32;
  localparam int RegIdxWidth = 3;

  localparam logic [7:0] SwitchLimit = 8'd5;

  // register word index
  typedef enum logic [RegIdxWidth-1:0] {
    RegTempLowBand  = 3'd0,
    RegTempHighBand = 3'd1,
    RegCo2LowBand   = 3'd2,
    RegCo2HighBand  = 3'd3,
    RegDoorMode     = 3'd4,
    RegDoorDelay    = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    DoorOff    = 2'd0,
    DoorOnHigh = 2'd1,
    DoorOnLow  = 2'd2,
    DoorRsvd   = 2'd3
  } door_mode_e;

  // alarm flag bits
  localparam int AlmSwitch  = 0;
  localparam int AlmTempLow = 1;
  localparam int AlmTempHi  = 2;
  localparam int AlmCo2Low  = 3;
  localparam int AlmCo2Hi   = 4;
  localparam int AlmDoor    = 5;

  // notify bits
  localparam int NtfTempLow = 0;
  localparam int NtfTempHi  = 1;
  localparam int NtfCo2Low  = 2;
  localparam int NtfCo2Hi   = 3;
  localparam int NtfDoor    = 4;

  typedef struct packed {
    logic signed [15:0] temp_low_band;
    logic signed [15:0] temp_high_band;
    logic signed [15:0] co2_low_band;
    logic signed [15:0] co2_high_band;
    door_mode_e         door_mode;
    logic [7:0]         door_delay;
  } cfg_t;

  typedef struct packed {
    logic               run_request;
    logic [7:0]         switch_level;
    logic signed [15:0] temp_measured;
    logic signed [15:0] temp_target;
    logic               temp_stable;
    logic signed [15:0] co2_measured;
    logic signed [15:0] co2_target;
    logic               co2_stable;
    logic               door_state;
    logic               second_tick;
  } item_t;

  typedef struct packed {
    logic [5:0] held_alarms;
    logic [4:0] notify_latches;
    logic [7:0] door_count;
  } state_t;

  typedef struct packed {
    logic [5:0] alarm_flags;
    logic [4:0] notify_events;
    logic       run_forced_off;
    logic       clear_temp_stable;
    logic       clear_co2_stable;
  } result_t;

endpackage

// ----- rtl/core/dam_regs.sv -----
// ----------------------------------------------------------------------------
// dam_regs
// APB register file holding the band, door mode and door delay settings.
// ----------------------------------------------------------------------------
module dam_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dam_pkg::AddrWidth-1:0] paddr,
  input  logic [dam_pkg::DataWidth-1:0] pwdata,
  output logic [dam_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  output dam_pkg::cfg_t                 cfg_o
);
  import dam_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[RegIdxWidth+1:2]);
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegTempLowBand:  cfg_d.temp_low_band  = pwdata[15:0];
        RegTempHighBand: cfg_d.temp_high_band = pwdata[15:0];
        RegCo2LowBand:   cfg_d.co2_low_band   = pwdata[15:0];
        RegCo2HighBand:  cfg_d.co2_high_band  = pwdata[15:0];
        RegDoorMode:     cfg_d.door_mode      = door_mode_e'(pwdata[1:0]);
        RegDoorDelay:    cfg_d.door_delay     = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{
        temp_low_band:  16'sd0,
        temp_high_band: 16'sd0,
        co2_low_band:   16'sd0,
        co2_high_band:  16'sd0,
        door_mode:      DoorOff,
        door_delay:     8'd0
      };
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (idx)
      RegTempLowBand:  prdata = {{16{cfg_q.temp_low_band[15]}}, cfg_q.temp_low_band};
      RegTempHighBand: prdata = {{16{cfg_q.temp_high_band[15]}}, cfg_q.temp_high_band};
      RegCo2LowBand:   prdata = {{16{cfg_q.co2_low_band[15]}}, cfg_q.co2_low_band};
      RegCo2HighBand:  prdata = {{16{cfg_q.co2_high_band[15]}}, cfg_q.co2_high_band};
      RegDoorMode:     prdata = {30'd0, cfg_q.door_mode};
      RegDoorDelay:    prdata = {24'd0, cfg_q.door_delay};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/dam_eval.sv -----
// ----------------------------------------------------------------------------
// dam_eval
// Single-pass alarm evaluation of one tick word against the held state.
// ----------------------------------------------------------------------------
module dam_eval (
  input  dam_pkg::cfg_t    cfg_i,
  input  dam_pkg::item_t   item_i,
  input  dam_pkg::state_t  state_i,
  output dam_pkg::state_t  state_o,
  output dam_pkg::result_t result_o
);
  import dam_pkg::*;

  typedef struct packed {
    logic alm_lo;
    logic alm_hi;
    logic ntf_lo;
    logic ntf_hi;
    logic ev_lo;
    logic ev_hi;
  } band_t;

  function automatic band_t check_band(
    input logic signed [15:0] meas,
    input logic signed [15:0] tgt,
    input logic               stable,
    input logic signed [15:0] lo_band,
    input logic signed [15:0] hi_band,
    input logic               alm_lo,
    input logic               alm_hi,
    input logic               ntf_lo,
    input logic               ntf_hi
  );
    band_t              r;
    logic signed [17:0] m, t, lw, hw, lim_lo, lim_hi;
    m      = {{2{meas[15]}}, meas};
    t      = {{2{tgt[15]}}, tgt};
    lw     = {{2{lo_band[15]}}, lo_band};
    hw     = {{2{hi_band[15]}}, hi_band};
    lim_lo = t - lw;
    lim_hi = t + hw;
    r      = '{alm_lo: alm_lo, alm_hi: alm_hi, ntf_lo: ntf_lo, ntf_hi: ntf_hi,
               ev_lo: 1'b0, ev_hi: 1'b0};
    if (m < t) begin
      if (stable && (lw > 18'sd0) && (m < lim_lo)) begin
        r.alm_lo = 1'b1;
        r.ntf_lo = 1'b1;
        r.ev_lo  = ~ntf_lo;
      end else begin
        r.alm_lo = 1'b0;
        r.ntf_lo = 1'b0;
      end
    end else if (m > t) begin
      if (stable && (hw > 18'sd0) && (m > lim_hi)) begin
        r.alm_hi = 1'b1;
        r.ntf_hi = 1'b1;
        r.ev_hi  = ~ntf_hi;
      end else begin
        r.alm_hi = 1'b0;
        r.ntf_hi = 1'b0;
      end
    end else begin
      // on target: both sides clear, latches kept
      r.alm_lo = 1'b0;
      r.alm_hi = 1'b0;
    end
    return r;
  endfunction

  logic       forced, run, door_cond;
  logic [7:0] cnt_inc;
  band_t      temp_r, co2_r;
  logic [5:0] held;
  logic [4:0] ntf, ev;
  logic [7:0] cnt;

  assign forced = item_i.switch_level > SwitchLimit;
  assign run    = item_i.run_request & ~forced;

  assign temp_r = check_band(item_i.temp_measured, item_i.temp_target, item_i.temp_stable,
                             cfg_i.temp_low_band, cfg_i.temp_high_band,
                             state_i.held_alarms[AlmTempLow], state_i.held_alarms[AlmTempHi],
                             state_i.notify_latches[NtfTempLow],
                             state_i.notify_latches[NtfTempHi]);

  assign co2_r = check_band(item_i.co2_measured, item_i.co2_target, item_i.co2_stable,
                            cfg_i.co2_low_band, cfg_i.co2_high_band,
                            state_i.held_alarms[AlmCo2Low], state_i.held_alarms[AlmCo2Hi],
                            state_i.notify_latches[NtfCo2Low],
                            state_i.notify_latches[NtfCo2Hi]);

  assign door_cond = ((cfg_i.door_mode == DoorOnLow) && !item_i.door_state) ||
                     ((cfg_i.door_mode == DoorOnHigh) && item_i.door_state);

  assign cnt_inc = (item_i.second_tick && (state_i.door_count < cfg_i.door_delay)) ?
                   state_i.door_count + 8'd1 : state_i.door_count;

  always_comb begin
    held = state_i.held_alarms;
    ntf  = state_i.notify_latches;
    cnt  = state_i.door_count;
    ev   = '0;

    held[AlmSwitch] = forced;

    if (run) begin
      held[AlmTempLow] = temp_r.alm_lo;
      held[AlmTempHi]  = temp_r.alm_hi;
      ntf[NtfTempLow]  = temp_r.ntf_lo;
      ntf[NtfTempHi]   = temp_r.ntf_hi;
      ev[NtfTempLow]   = temp_r.ev_lo;
      ev[NtfTempHi]    = temp_r.ev_hi;

      held[AlmCo2Low]  = co2_r.alm_lo;
      held[AlmCo2Hi]   = co2_r.alm_hi;
      ntf[NtfCo2Low]   = co2_r.ntf_lo;
      ntf[NtfCo2Hi]    = co2_r.ntf_hi;
      ev[NtfCo2Low]    = co2_r.ev_lo;
      ev[NtfCo2Hi]     = co2_r.ev_hi;

      if (door_cond) begin
        cnt = cnt_inc;
        if (cnt_inc >= cfg_i.door_delay) begin
          held[AlmDoor] = 1'b1;
          ntf[NtfDoor]  = 1'b1;
          ev[NtfDoor]   = ~state_i.notify_latches[NtfDoor];
        end
      end else begin
        held[AlmDoor] = 1'b0;
        ntf[NtfDoor]  = 1'b0;
        cnt           = '0;
      end
    end else begin
      held[AlmDoor:AlmTempLow] = '0;
    end
  end

  assign state_o.held_alarms    = held;
  assign state_o.notify_latches = ntf;
  assign state_o.door_count     = cnt;

  assign result_o.alarm_flags       = held;
  assign result_o.notify_events     = ev;
  assign result_o.run_forced_off    = forced;
  assign result_o.clear_temp_stable = ~run;
  assign result_o.clear_co2_stable  = ~run;

endmodule

// ----- rtl/core/deviation_alarm_monitor.sv -----
// An accepted word is held in the input register, its result word in the result register.
// One word per cycle unless the output stalls; the input register refills as results drain.
// The result register is the only stall point; input stalls only when both stages are full.
// Reset (rst_ni low, asynchronous): pipeline empty, alarms, notify latches, door count
// and all configuration registers cleared.
// ----------------------------------------------------------------------------
// deviation_alarm_monitor
// Tick-rate alarm monitor: switch, temperature and CO2 deviation, door delay.
// ----------------------------------------------------------------------------
module deviation_alarm_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          run_request_i,
  input  logic [7:0]                    switch_level_i,
  input  logic signed [15:0]            temp_measured_i,
  input  logic signed [15:0]            temp_target_i,
  input  logic                          temp_stable_i,
  input  logic signed [15:0]            co2_measured_i,
  input  logic signed [15:0]            co2_target_i,
  input  logic                          co2_stable_i,
  input  logic                          door_state_i,
  input  logic                          second_tick_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [5:0]                    alarm_flags_o,
  output logic [4:0]                    notify_events_o,
  output logic                          run_forced_off_o,
  output logic                          clear_temp_stable_o,
  output logic                          clear_co2_stable_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dam_pkg::AddrWidth-1:0] paddr,
  input  logic [dam_pkg::DataWidth-1:0] pwdata,
  output logic [dam_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);
  import dam_pkg::*;

  `include "assert_macros.svh"

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q, in_valid_d;
  logic    out_valid_q;
  logic    advance, accept;
  state_t  state_q, state_next;
  result_t result_q, result_next;

  dam_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance    = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = in_valid_q & ~advance;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{
        run_request:   run_request_i,
        switch_level:  switch_level_i,
        temp_measured: temp_measured_i,
        temp_target:   temp_target_i,
        temp_stable:   temp_stable_i,
        co2_measured:  co2_measured_i,
        co2_target:    co2_target_i,
        co2_stable:    co2_stable_i,
        door_state:    door_state_i,
        second_tick:   second_tick_i
      };
    end
  end

  dam_eval u_eval (
    .cfg_i    (cfg),
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_next),
    .result_o (result_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (advance) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          state_q <= state_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      result_q <= result_next;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign alarm_flags_o       = result_q.alarm_flags;
  assign notify_events_o     = result_q.notify_events;
  assign run_forced_off_o    = result_q.run_forced_off;
  assign clear_temp_stable_o = result_q.clear_temp_stable;
  assign clear_co2_stable_o  = result_q.clear_co2_stable;

  `ASSERT_CHECK(a_switch_flag, clk_i, rst_ni, out_valid_o |-> (alarm_flags_o[AlmSwitch] == run_forced_off_o))
  `ASSERT_CHECK(a_forced_stops, clk_i, rst_ni, (out_valid_o && run_forced_off_o) |-> (clear_temp_stable_o && clear_co2_stable_o))
  `ASSERT_CHECK(a_idle_no_alarm, clk_i, rst_ni, (out_valid_o && clear_temp_stable_o) |-> ((alarm_flags_o[AlmDoor:AlmTempLow] == 5'd0) && (notify_events_o == 5'd0)))
  `ASSERT_NEVER(a_event_wo_alarm, clk_i, rst_ni, out_valid_o && ((notify_events_o & ~alarm_flags_o[AlmDoor:AlmTempLow]) != 5'd0))
  `ASSERT_CHECK(a_state_hold, clk_i, rst_ni, !(advance && in_valid_q) |=> (state_q == $past(state_q)))

endmodule
